// File: hdl/cbt_pkg.sv
// Shared types and constants for the cubic Bezier tessellator.
`default_nettype none

package cbt_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int WGT_W = FRAC_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;
    localparam logic [FRAC_W-1:0] STEP_MIN = 16'd2048;
    localparam logic [FRAC_W-1:0] STEP_RESET = 16'd6554;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [WGT_W-1:0] w0;
        logic [WGT_W-1:0] w1;
        logic [WGT_W-1:0] w2;
        logic [WGT_W-1:0] w3;
    } t_weights;

    typedef struct packed {
        logic closing;
        logic last;
    } t_tag;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

// File: hdl/cbt_in_if.sv
// Input channel carrying one knot triple per beat.
`default_nettype none

interface cbt_in_if;
    logic valid;
    logic ready;
    cbt_pkg::t_coord left_x;
    cbt_pkg::t_coord left_y;
    cbt_pkg::t_coord left_z;
    cbt_pkg::t_coord knot_x;
    cbt_pkg::t_coord knot_y;
    cbt_pkg::t_coord knot_z;
    cbt_pkg::t_coord right_x;
    cbt_pkg::t_coord right_y;
    cbt_pkg::t_coord right_z;
    logic end_of_curve;

    modport source (
        output valid, left_x, left_y, left_z, knot_x, knot_y, knot_z,
        output right_x, right_y, right_z, end_of_curve,
        input ready
    );
    modport sink (
        input valid, left_x, left_y, left_z, knot_x, knot_y, knot_z,
        input right_x, right_y, right_z, end_of_curve,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/cbt_out_if.sv
// Output channel carrying one tessellated point per beat.
`default_nettype none

interface cbt_out_if;
    logic valid;
    logic ready;
    cbt_pkg::t_coord point_x;
    cbt_pkg::t_coord point_y;
    cbt_pkg::t_coord point_z;
    logic closing_segment;
    logic last_point;

    modport source (
        output valid, point_x, point_y, point_z, closing_segment, last_point,
        input ready
    );
    modport sink (
        input valid, point_x, point_y, point_z, closing_segment, last_point,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/cbt_weights.sv
// Two-stage Bernstein weight generator for one parameter value per cycle while enabled.
`default_nettype none

module cbt_weights (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cbt_pkg::FRAC_W-1:0]   i_tt,
    output cbt_pkg::t_weights            o_w
);

    logic [16:0] yt;
    logic [18:0] yt3;
    logic [33:0] p_yy;
    logic [34:0] p_ytt;
    logic [31:0] p_tt;

    logic [16:0] r_t1;
    logic [16:0] r_t2;
    logic [15:0] r_sq;
    logic [16:0] r_yt;
    logic [15:0] r_tt;

    logic [33:0] q0;
    logic [33:0] q1;
    logic [32:0] q2;
    logic [31:0] q3;

    cbt_pkg::t_weights r_w;

    always_comb begin
        yt = cbt_pkg::ONE_Q16 - {1'b0, i_tt};
        yt3 = {1'b0, yt, 1'b0} + {2'b00, yt};
        p_yy = {17'b0, yt} * {17'b0, yt};
        p_ytt = {16'b0, yt3} * {19'b0, i_tt};
        p_tt = {16'b0, i_tt} * {16'b0, i_tt};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= p_yy[32:16];
            r_t2 <= p_ytt[32:16];
            r_sq <= p_tt[31:16];
            r_yt <= yt;
            r_tt <= i_tt;
        end
    end

    always_comb begin
        q0 = {17'b0, r_t1} * {17'b0, r_yt};
        q1 = {17'b0, r_t2} * {17'b0, r_yt};
        q2 = {16'b0, r_t2} * {17'b0, r_tt};
        q3 = {16'b0, r_sq} * {16'b0, r_tt};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w.w0 <= q0[32:16];
            r_w.w1 <= q1[32:16];
            r_w.w2 <= q2[32:16];
            r_w.w3 <= {1'b0, q3[31:16]};
        end
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

// File: hdl/cbt_lane.sv
// One coordinate lane: four weighted terms, their sum and saturation.
`default_nettype none

module cbt_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  cbt_pkg::t_coord   i_p0,
    input  cbt_pkg::t_coord   i_p1,
    input  cbt_pkg::t_coord   i_p2,
    input  cbt_pkg::t_coord   i_p3,
    input  cbt_pkg::t_weights i_w,
    output cbt_pkg::t_coord   o_point
);

    localparam int PROD_W = cbt_pkg::COORD_W + cbt_pkg::WGT_W + 1;
    localparam int SUM_W = cbt_pkg::COORD_W + 2;

    logic signed [PROD_W-1:0] pr0;
    logic signed [PROD_W-1:0] pr1;
    logic signed [PROD_W-1:0] pr2;
    logic signed [PROD_W-1:0] pr3;

    cbt_pkg::t_coord r_t0;
    cbt_pkg::t_coord r_t1;
    cbt_pkg::t_coord r_t2;
    cbt_pkg::t_coord r_t3;

    logic signed [SUM_W-1:0] sum;
    cbt_pkg::t_coord sat;
    cbt_pkg::t_coord r_point;

    always_comb begin
        pr0 = PROD_W'(i_p0) * PROD_W'($signed({1'b0, i_w.w0}));
        pr1 = PROD_W'(i_p1) * PROD_W'($signed({1'b0, i_w.w1}));
        pr2 = PROD_W'(i_p2) * PROD_W'($signed({1'b0, i_w.w2}));
        pr3 = PROD_W'(i_p3) * PROD_W'($signed({1'b0, i_w.w3}));
    end

    // Each term lies between zero and its coordinate, so it fits a coordinate.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0 <= pr0[cbt_pkg::COORD_W+cbt_pkg::FRAC_W-1:cbt_pkg::FRAC_W];
            r_t1 <= pr1[cbt_pkg::COORD_W+cbt_pkg::FRAC_W-1:cbt_pkg::FRAC_W];
            r_t2 <= pr2[cbt_pkg::COORD_W+cbt_pkg::FRAC_W-1:cbt_pkg::FRAC_W];
            r_t3 <= pr3[cbt_pkg::COORD_W+cbt_pkg::FRAC_W-1:cbt_pkg::FRAC_W];
        end
    end

    always_comb begin
        sum = SUM_W'(r_t0) + SUM_W'(r_t1) + SUM_W'(r_t2) + SUM_W'(r_t3);
        if (sum[SUM_W-1] == 1'b0 && sum[SUM_W-2:cbt_pkg::COORD_W-1] != '0) begin
            sat = {1'b0, {(cbt_pkg::COORD_W-1){1'b1}}};
        end else if (sum[SUM_W-1] == 1'b1 && sum[SUM_W-2:cbt_pkg::COORD_W-1] != '1) begin
            sat = {1'b1, {(cbt_pkg::COORD_W-1){1'b0}}};
        end else begin
            sat = sum[cbt_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_point <= sat;
        end
    end

    assign o_point = r_point;

endmodule

`default_nettype wire

// File: hdl/cubic_bezier_tessellator.sv
// Top level: triple storage, segment sequencer, weight generator and three coordinate lanes.
// The first point of a triple passes the sequencer, the weight stages and the lane stages.
// Throughput: one point per cycle while the output accepts, ceil(65536 / step) points per
// segment, at most 32, and up to two segments per triple; a stalled output holds the pipeline.
// A new triple is taken only once the sequencer is idle and the weight stages are empty.
// Reset is synchronous and active low; it clears the curve state and sets step to 6554.
`default_nettype none

module cubic_bezier_tessellator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cbt_in_if.sink                            i_tri,
    cbt_out_if.source                         o_pt,
    input  logic                              i_cfg_we,
    input  logic [cbt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cbt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    cbt_pkg::t_state r_state;
    cbt_pkg::t_state n_state;
    logic [cbt_pkg::FRAC_W-1:0] r_tt;
    logic [cbt_pkg::FRAC_W-1:0] n_tt;
    logic r_closing;
    logic n_closing;
    logic r_pend;
    logic n_pend;
    logic r_have_prev;
    logic [cbt_pkg::FRAC_W-1:0] r_step;
    logic r_cyclic;

    cbt_pkg::t_coord in_left [3];
    cbt_pkg::t_coord in_knot [3];
    cbt_pkg::t_coord in_right [3];

    cbt_pkg::t_coord r_prev_knot [3];
    cbt_pkg::t_coord r_prev_right [3];
    cbt_pkg::t_coord r_first_left [3];
    cbt_pkg::t_coord r_first_knot [3];
    cbt_pkg::t_coord r_sa0 [3];
    cbt_pkg::t_coord r_sa1 [3];
    cbt_pkg::t_coord r_sa2 [3];
    cbt_pkg::t_coord r_sa3 [3];

    cbt_pkg::t_coord lane_p0 [3];
    cbt_pkg::t_coord lane_p1 [3];
    cbt_pkg::t_coord lane_p2 [3];
    cbt_pkg::t_coord lane_p3 [3];
    cbt_pkg::t_coord lane_out [3];

    logic en;
    logic in_rdy;
    logic acc;
    logic do_close;
    logic issue;
    logic seg_end;
    logic [cbt_pkg::FRAC_W-1:0] step_eff;
    logic [cbt_pkg::FRAC_W:0] tt_next;
    cbt_pkg::t_tag issue_tag;

    logic r_va;
    logic r_vb;
    logic r_v1;
    logic r_v2;
    cbt_pkg::t_tag r_ta;
    cbt_pkg::t_tag r_tb;
    cbt_pkg::t_tag r_t1;
    cbt_pkg::t_tag r_t2;

    cbt_pkg::t_weights wts;

    assign in_left[0] = i_tri.left_x;
    assign in_left[1] = i_tri.left_y;
    assign in_left[2] = i_tri.left_z;
    assign in_knot[0] = i_tri.knot_x;
    assign in_knot[1] = i_tri.knot_y;
    assign in_knot[2] = i_tri.knot_z;
    assign in_right[0] = i_tri.right_x;
    assign in_right[1] = i_tri.right_y;
    assign in_right[2] = i_tri.right_z;

    // The whole point pipeline advances whenever the output register can move.
    assign en = !r_v2 || o_pt.ready;

    // Control points are read when a point leaves the weight stages, so those must be empty.
    assign in_rdy = (r_state == cbt_pkg::ST_IDLE) && !r_va && !r_vb;
    assign i_tri.ready = in_rdy;
    assign acc = i_tri.valid && in_rdy;
    assign do_close = i_tri.end_of_curve && r_cyclic;

    assign step_eff = (r_step < cbt_pkg::STEP_MIN) ? cbt_pkg::STEP_MIN : r_step;
    assign tt_next = {1'b0, r_tt} + {1'b0, step_eff};
    assign seg_end = tt_next[cbt_pkg::FRAC_W];
    assign issue = (r_state == cbt_pkg::ST_RUN) && en;
    assign issue_tag.closing = r_closing;
    assign issue_tag.last = seg_end && !r_pend;

    always_comb begin
        n_state = r_state;
        n_tt = r_tt;
        n_closing = r_closing;
        n_pend = r_pend;
        unique case (r_state)
            cbt_pkg::ST_IDLE: begin
                if (acc) begin
                    if (r_have_prev) begin
                        n_state = cbt_pkg::ST_RUN;
                        n_tt = '0;
                        n_closing = 1'b0;
                        n_pend = do_close;
                    end else if (do_close) begin
                        n_state = cbt_pkg::ST_RUN;
                        n_tt = '0;
                        n_closing = 1'b1;
                        n_pend = 1'b0;
                    end
                end
            end
            cbt_pkg::ST_RUN: begin
                if (en) begin
                    if (seg_end) begin
                        if (r_pend) begin
                            n_tt = '0;
                            n_closing = 1'b1;
                            n_pend = 1'b0;
                        end else begin
                            n_state = cbt_pkg::ST_IDLE;
                        end
                    end else begin
                        n_tt = tt_next[cbt_pkg::FRAC_W-1:0];
                    end
                end
            end
            default: begin
                n_state = cbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbt_pkg::ST_IDLE;
            r_tt <= '0;
            r_closing <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tt <= n_tt;
            r_closing <= n_closing;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cbt_pkg::STEP_RESET;
            r_cyclic <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbt_pkg::CFG_STEP: r_step <= i_cfg_data;
                cbt_pkg::CFG_CYCLIC: r_cyclic <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (acc) begin
            r_have_prev <= !i_tri.end_of_curve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int a = 0; a < 3; a++) begin
                r_sa0[a] <= r_prev_knot[a];
                r_sa1[a] <= r_prev_right[a];
                r_sa2[a] <= in_left[a];
                r_sa3[a] <= in_knot[a];
                r_prev_knot[a] <= in_knot[a];
                r_prev_right[a] <= in_right[a];
                if (!r_have_prev) begin
                    r_first_left[a] <= in_left[a];
                    r_first_knot[a] <= in_knot[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_va <= issue;
            r_vb <= r_va;
            r_v1 <= r_vb;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ta <= issue_tag;
            r_tb <= r_ta;
            r_t1 <= r_tb;
            r_t2 <= r_t1;
        end
    end

    cbt_weights u_weights (
        .i_clk (i_clk),
        .i_en  (en),
        .i_tt  (r_tt),
        .o_w   (wts)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lane_p0[a] = r_tb.closing ? r_prev_knot[a] : r_sa0[a];
            lane_p1[a] = r_tb.closing ? r_prev_right[a] : r_sa1[a];
            lane_p2[a] = r_tb.closing ? r_first_left[a] : r_sa2[a];
            lane_p3[a] = r_tb.closing ? r_first_knot[a] : r_sa3[a];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        cbt_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_p0    (lane_p0[g]),
            .i_p1    (lane_p1[g]),
            .i_p2    (lane_p2[g]),
            .i_p3    (lane_p3[g]),
            .i_w     (wts),
            .o_point (lane_out[g])
        );
    end

    assign o_pt.valid = r_v2;
    assign o_pt.point_x = lane_out[0];
    assign o_pt.point_y = lane_out[1];
    assign o_pt.point_z = lane_out[2];
    assign o_pt.closing_segment = r_t2.closing;
    assign o_pt.last_point = r_t2.last;

endmodule

`default_nettype wire
